FILE: sv/grdd_pkg.sv
// Shared types and constants for the grid row difference decoder.
`timescale 1ns / 1ps

package grdd_pkg;

    localparam logic [31:0] UNDEF_VALUE = 32'h7FFF_FFFF;
    localparam logic [15:0] UNDEF_16    = 16'h7FFF;
    localparam logic [7:0]  UNDEF_8     = 8'h7F;

    // Difference orders in a section header.
    localparam logic [1:0] DIF_RAW    = 2'd0;
    localparam logic [1:0] DIF_FIRST  = 2'd1;
    localparam logic [1:0] DIF_SECOND = 2'd2;
    localparam logic [1:0] DIF_BAD    = 2'd3;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_ROW_FORMAT = 2'd0;
    localparam logic [1:0] REG_COLUMNS    = 2'd1;
    localparam logic [1:0] REG_DIMENSIONS = 2'd2;

    typedef struct packed {
        logic signed [31:0] value;
        logic               is_undefined;
        logic [11:0]        column;
        logic [1:0]         dimension;
        logic [12:0]        run_length;
        logic               status;
        logic               last_of_row;
    } result_t;

endpackage

FILE: sv/grid_row_difference_decoder_top.sv
// Grid row decoder: byte stream in, grid values and undefined runs out.
`timescale 1ns / 1ps

// One byte is taken per transaction and is decoded in the cycle it is accepted;
// a byte can produce up to two results, which are held in a three-entry
// result buffer and delivered one per cycle while out_ready is high. A new
// byte is accepted whenever the buffer is empty or is handing over its last
// result, so the rate is one byte per cycle while bytes yield at most one
// result each and out_ready is high. Configuration must only be written
// while the decoder is idle; row_format is sampled on row_start.
module grid_row_difference_decoder_top #(
    parameter int MAX_COLUMNS    = 4096,
    parameter int MAX_DIMENSIONS = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               row_start,
    input  logic [7:0]         data_byte,
    // output channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] value,
    output logic               is_undefined,
    output logic [11:0]        column,
    output logic [1:0]         dimension,
    output logic [12:0]        run_length,
    output logic               status,
    output logic               last_of_row
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_PLAIN, PH_HEAD, PH_FIRST, PH_LAST,
        PH_START, PH_SLOPE, PH_VALUES, PH_DONE
    } phase_t;

    logic              row_format_reg;
    logic [12:0]       columns_reg;
    logic [2:0]        dimensions_reg;

    phase_t            phase_reg, phase_next;
    logic [31:0]       gather_reg, gather_next;
    logic [2:0]        count_reg, count_next;
    logic [7:0]        flags_reg, flags_next;
    logic signed [16:0] rlo_reg, rlo_next;
    logic signed [16:0] rhi_reg, rhi_next;
    logic signed [16:0] cnow_reg, cnow_next;
    logic [2:0]        dnow_reg, dnow_next;
    logic [31:0]       acc1_reg, acc1_next;
    logic [31:0]       acc2_reg, acc2_next;

    grdd_pkg::result_t res_reg [3];
    grdd_pkg::result_t res_next [3];
    logic [1:0]        rcnt_reg, rcnt_next;
    logic [1:0]        rhead_reg;
    logic [1:0]        n_res;

    logic              in_fire, out_fire, cfg_write;
    logic signed [16:0] cols;
    logic [3:0]        dims;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[3:2])
            grdd_pkg::REG_ROW_FORMAT: prdata = {31'd0, row_format_reg};
            grdd_pkg::REG_COLUMNS:    prdata = {19'd0, columns_reg};
            grdd_pkg::REG_DIMENSIONS: prdata = {29'd0, dimensions_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // Live clamps of the geometry registers.
    always_comb
    begin
        if (columns_reg < 13'd4)
            cols = 17'sd4;
        else if ({4'd0, columns_reg} > 17'(MAX_COLUMNS))
            cols = 17'(MAX_COLUMNS);
        else
            cols = signed'({4'd0, columns_reg});
        if (dimensions_reg == 3'd0)
            dims = 4'd1;
        else if ({1'b0, dimensions_reg} > 4'(MAX_DIMENSIONS))
            dims = 4'(MAX_DIMENSIONS);
        else
            dims = {1'b0, dimensions_reg};
    end

    assign in_ready  = (rcnt_reg == 2'd0) || (rcnt_reg == 2'd1 && out_ready);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = (rcnt_reg != 2'd0);
    assign out_fire  = out_valid && out_ready;

    assign value        = res_reg[rhead_reg].value;
    assign is_undefined = res_reg[rhead_reg].is_undefined;
    assign column       = res_reg[rhead_reg].column;
    assign dimension    = res_reg[rhead_reg].dimension;
    assign run_length   = res_reg[rhead_reg].run_length;
    assign status       = res_reg[rhead_reg].status;
    assign last_of_row  = res_reg[rhead_reg].last_of_row;

    // Decode of one accepted byte.
    always_comb
    begin
        logic [31:0]        w;
        logic [3:0]         needed;
        logic [3:0]         cnt_inc;
        logic [1:0]         dif;
        logic [3:0]         width;
        logic signed [16:0] s;
        logic signed [16:0] start;
        logic [31:0]        v;
        logic [3:0]         dplus;
        logic               do_after_range, do_begin, do_end_section;
        logic               do_finish, do_end_row, do_fail;

        phase_next  = phase_reg;
        gather_next = gather_reg;
        count_next  = count_reg;
        flags_next  = flags_reg;
        rlo_next    = rlo_reg;
        rhi_next    = rhi_reg;
        cnow_next   = cnow_reg;
        dnow_next   = dnow_reg;
        acc1_next   = acc1_reg;
        acc2_next   = acc2_reg;
        for (int i = 0; i < 3; i++)
            res_next[i] = res_reg[i];
        n_res = 2'd0;

        w = 32'd0; needed = 4'd2; cnt_inc = 4'd0; dif = 2'd0; width = 4'd0;
        s = 17'sd0; start = 17'sd0; v = 32'd0; dplus = 4'd0;
        do_after_range = 1'b0; do_begin = 1'b0; do_end_section = 1'b0;
        do_finish = 1'b0; do_end_row = 1'b0; do_fail = 1'b0;

        if (row_start)
        begin
            gather_next = 32'd0;
            count_next  = 3'd0;
            flags_next  = 8'd0;
            rlo_next    = 17'sd0;
            rhi_next    = -17'sd1;
            cnow_next   = 17'sd0;
            dnow_next   = 3'd0;
            acc1_next   = 32'd0;
            acc2_next   = 32'd0;
            phase_next  = row_format_reg ? PH_HEAD : PH_PLAIN;
        end

        if (phase_next != PH_IDLE && phase_next != PH_DONE)
        begin
            w = gather_next | ({24'd0, data_byte} << {count_next[1:0], 3'b000});
            cnt_inc = {1'b0, count_next} + 4'd1;
            if (phase_next == PH_START || phase_next == PH_SLOPE)
                needed = 4'd4;
            else if (phase_next == PH_VALUES)
                needed = flags_next[7:4];
            else
                needed = 4'd2;

            if (cnt_inc < needed)
            begin
                gather_next = w;
                count_next  = cnt_inc[2:0];
            end
            else
            begin
                gather_next = 32'd0;
                count_next  = 3'd0;
                dif = flags_next[3:2];
                case (phase_next)
                    PH_PLAIN:
                    begin
                        v = (w[15:0] == grdd_pkg::UNDEF_16) ? grdd_pkg::UNDEF_VALUE
                                                              : {{16{w[15]}}, w[15:0]};
                        res_next[n_res] = '{v, v == grdd_pkg::UNDEF_VALUE,
                                            cnow_next[11:0], dnow_next[1:0], 13'd1,
                                            1'b0, 1'b0};
                        n_res = n_res + 2'd1;
                        dplus = {1'b0, dnow_next} + 4'd1;
                        if (dplus >= dims)
                        begin
                            dnow_next = 3'd0;
                            cnow_next = cnow_next + 17'sd1;
                        end
                        else
                            dnow_next = dplus[2:0];
                        if (cnow_next >= cols)
                            do_end_row = 1'b1;
                    end
                    PH_HEAD:
                    begin
                        dif   = w[3:2];
                        width = w[7:4];
                        if (dif == grdd_pkg::DIF_BAD || w[15:8] != 8'd0 ||
                            (width != 4'd1 && width != 4'd2 && width != 4'd4))
                            do_fail = 1'b1;
                        else if (w[1] && !w[0])
                            do_finish = 1'b1;
                        else
                        begin
                            flags_next = w[7:0];
                            if (w[0])
                                phase_next = PH_FIRST;
                            else
                            begin
                                rlo_next = rhi_next + 17'sd1;
                                rhi_next = cols - 17'sd1;
                                do_after_range = 1'b1;
                            end
                        end
                    end
                    PH_FIRST:
                    begin
                        s = {w[15], w[15:0]};
                        if (s < rhi_next + 17'sd1 || s >= cols)
                            do_fail = 1'b1;
                        else
                        begin
                            rlo_next   = s;
                            phase_next = PH_LAST;
                        end
                    end
                    PH_LAST:
                    begin
                        s = {w[15], w[15:0]};
                        if (s < rlo_next || s >= cols)
                            do_fail = 1'b1;
                        else
                        begin
                            start = rhi_next + 17'sd1;
                            if (rlo_next > start)
                            begin
                                res_next[n_res] = '{grdd_pkg::UNDEF_VALUE, 1'b1,
                                                    start[11:0], dnow_next[1:0],
                                                    13'(rlo_next - start), 1'b0, 1'b0};
                                n_res = n_res + 2'd1;
                            end
                            rhi_next = s;
                            do_after_range = 1'b1;
                        end
                    end
                    PH_START:
                    begin
                        acc1_next = w;
                        if (dif >= grdd_pkg::DIF_SECOND)
                            phase_next = PH_SLOPE;
                        else
                            do_begin = 1'b1;
                    end
                    PH_SLOPE:
                    begin
                        acc2_next = w;
                        do_begin  = 1'b1;
                    end
                    PH_VALUES:
                    begin
                        width = flags_next[7:4];
                        if (dif != grdd_pkg::DIF_RAW && cnow_next == rlo_next)
                            v = acc1_next;
                        else
                        begin
                            if (width == 4'd1)
                                v = (w[7:0] == grdd_pkg::UNDEF_8) ? grdd_pkg::UNDEF_VALUE
                                                                   : {{24{w[7]}}, w[7:0]};
                            else if (width == 4'd2)
                                v = (w[15:0] == grdd_pkg::UNDEF_16) ? grdd_pkg::UNDEF_VALUE
                                                                     : {{16{w[15]}}, w[15:0]};
                            else
                                v = w;
                            // A marker value leaves the accumulators untouched.
                            if (v != grdd_pkg::UNDEF_VALUE)
                            begin
                                if (dif == grdd_pkg::DIF_FIRST)
                                begin
                                    acc1_next = acc1_next + v;
                                    v = acc1_next;
                                end
                                else if (dif == grdd_pkg::DIF_SECOND)
                                begin
                                    acc2_next = acc2_next + v;
                                    acc1_next = acc1_next + acc2_next;
                                    v = acc1_next;
                                end
                            end
                        end
                        res_next[n_res] = '{v, v == grdd_pkg::UNDEF_VALUE,
                                            cnow_next[11:0], dnow_next[1:0], 13'd1,
                                            1'b0, 1'b0};
                        n_res = n_res + 2'd1;
                        cnow_next = cnow_next + 17'sd1;
                        if (cnow_next > rhi_next)
                            do_end_section = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase

                if (do_after_range)
                begin
                    if (flags_next[3:2] != grdd_pkg::DIF_RAW)
                        phase_next = PH_START;
                    else
                        do_begin = 1'b1;
                end
                if (do_begin)
                begin
                    if (rlo_next > rhi_next)
                        do_end_section = 1'b1;
                    else
                    begin
                        cnow_next  = rlo_next;
                        phase_next = PH_VALUES;
                    end
                end
                if (do_end_section)
                begin
                    if (flags_next[1])
                        phase_next = PH_HEAD;
                    else
                        do_finish = 1'b1;
                end
                if (do_finish)
                begin
                    start = rhi_next + 17'sd1;
                    if (start < cols)
                    begin
                        res_next[n_res] = '{grdd_pkg::UNDEF_VALUE, 1'b1, start[11:0],
                                            dnow_next[1:0], 13'(cols - start), 1'b0, 1'b0};
                        n_res = n_res + 2'd1;
                    end
                    dplus = {1'b0, dnow_next} + 4'd1;
                    if (dplus >= dims)
                        do_end_row = 1'b1;
                    else
                    begin
                        dnow_next  = dplus[2:0];
                        rlo_next   = 17'sd0;
                        rhi_next   = -17'sd1;
                        phase_next = PH_HEAD;
                    end
                end
                if (do_fail)
                begin
                    res_next[n_res] = '{32'sd0, 1'b0, 12'd0, dnow_next[1:0], 13'd1,
                                        1'b1, 1'b1};
                    n_res = n_res + 2'd1;
                    phase_next = PH_DONE;
                end
                if (do_end_row)
                begin
                    phase_next = PH_DONE;
                    // A row that ends without any other result gets an end marker.
                    if (n_res == 2'd0)
                    begin
                        res_next[0] = '{grdd_pkg::UNDEF_VALUE, 1'b1, 12'd0,
                                        dnow_next[1:0], 13'd0, 1'b0, 1'b0};
                        n_res = 2'd1;
                    end
                    res_next[n_res - 2'd1].last_of_row = 1'b1;
                end
            end
        end

        if (in_fire)
            rcnt_next = n_res;
        else if (out_fire)
            rcnt_next = rcnt_reg - 2'd1;
        else
            rcnt_next = rcnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_format_reg <= 1'b1;
            columns_reg    <= 13'd4096;
            dimensions_reg <= 3'd1;
            phase_reg      <= PH_IDLE;
            gather_reg     <= 32'd0;
            count_reg      <= 3'd0;
            flags_reg      <= 8'd0;
            rlo_reg        <= 17'sd0;
            rhi_reg        <= -17'sd1;
            cnow_reg       <= 17'sd0;
            dnow_reg       <= 3'd0;
            acc1_reg       <= 32'd0;
            acc2_reg       <= 32'd0;
            rcnt_reg       <= 2'd0;
            rhead_reg      <= 2'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (paddr[3:2])
                    grdd_pkg::REG_ROW_FORMAT: row_format_reg <= pwdata[0];
                    grdd_pkg::REG_COLUMNS:    columns_reg    <= pwdata[12:0];
                    grdd_pkg::REG_DIMENSIONS: dimensions_reg <= pwdata[2:0];
                    default:                  ;
                endcase
            end
            if (in_fire)
            begin
                phase_reg  <= phase_next;
                gather_reg <= gather_next;
                count_reg  <= count_next;
                flags_reg  <= flags_next;
                rlo_reg    <= rlo_next;
                rhi_reg    <= rhi_next;
                cnow_reg   <= cnow_next;
                dnow_reg   <= dnow_next;
                acc1_reg   <= acc1_next;
                acc2_reg   <= acc2_next;
                rhead_reg  <= 2'd0;
            end
            else if (out_fire)
                rhead_reg <= rhead_reg + 2'd1;
            rcnt_reg <= rcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < 3; i++)
                res_reg[i] <= res_next[i];
        end
    end

endmodule
